>>> src/assert_macros.svh
// assertion macros used by multichannel_gain_ramp
// depends on nothing; clock aclk and reset aresetn must be in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define GMR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define GMR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/gmr_pkg.sv
// shared types and constants of the multichannel gain ramp
// used by gmr_lane and multichannel_gain_ramp
package gmr_pkg;

    localparam int RAMP_BITS    = 16;
    localparam int CMD_BITS     = 3;
    localparam int CCOUNT_BITS  = 4;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RAMP_LENGTH   = 2'd1;

    localparam logic [CCOUNT_BITS-1:0] CCOUNT_RESET = 4'd2;
    localparam logic [RAMP_BITS-1:0]   RAMP_RESET   = 16'd480;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_FRAME       = 3'd0,
        CMD_SET_MASTER  = 3'd1,
        CMD_SET_MUTE    = 3'd2,
        CMD_SET_CHANNEL = 3'd3,
        CMD_COMMIT      = 3'd4,
        CMD_ADVANCE     = 3'd5
    } gmr_cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COMMIT,
        S_DIV,
        S_AMUL,
        S_UPD,
        S_MUL1,
        S_MUL2,
        S_OUT
    } gmr_state_t;

    typedef struct packed {
        logic                 set_vol;
        logic                 div_load;
        logic                 div_run;
        logic                 div_last;
        logic                 commit;
        logic                 muted;
        logic                 amul;
        logic                 upd;
        logic                 upd_frame;
        logic                 snap;
        logic                 mul1;
        logic                 mul2;
        logic [RAMP_BITS-1:0] t;
    } gmr_ctl_t;

endpackage

>>> src/gmr_lane.sv
// one channel lane: volume, target, step divider, gain update and sample scaling
// depends on gmr_pkg
module gmr_lane #(
    parameter int SAMPLE_BITS    = 24,
    parameter int GAIN_FRAC_BITS = 20
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gmr_pkg::gmr_ctl_t             ctl,
    input  logic                          sel,
    input  logic                          en,
    input  logic [GAIN_FRAC_BITS+3:0]     vol,
    input  logic [GAIN_FRAC_BITS+3:0]     master,
    input  logic [gmr_pkg::RAMP_BITS-1:0] divisor,
    input  logic [SAMPLE_BITS-1:0]        sample,
    output logic                          vol_diff,
    output logic [SAMPLE_BITS-1:0]        res
);
    import gmr_pkg::*;

    localparam int S     = SAMPLE_BITS;
    localparam int F     = GAIN_FRAC_BITS;
    localparam int PB    = F + 4;
    localparam int GB    = 2 * F;
    localparam int IFRAC = 2 * F - 4;

    logic [PB-1:0]          chvol_reg;
    logic [GB-1:0]          cur_reg;
    logic [GB-1:0]          tgt_reg;
    logic signed [GB:0]     step_reg;
    logic [2*PB-1:0]        prod_reg;
    logic [RAMP_BITS-1:0]   dr_reg;
    logic [GB-1:0]          dq_reg;
    logic                   dneg_reg;
    logic signed [GB+1:0]   sprod_reg;
    logic [S+F-1:0]         plo_reg;
    logic [S+F-1:0]         phi_reg;
    logic                   neg_reg;
    logic [S-1:0]           res_reg;

    logic [RAMP_BITS:0]     trial;
    logic                   ge;
    logic [RAMP_BITS:0]     r_diff;
    logic [GB-1:0]          q_next;
    logic signed [GB:0]     diff;
    logic [GB-1:0]          diff_mag;
    logic signed [GB+RAMP_BITS+1:0] sprod_full;
    logic signed [GB+1:0]   addend;
    logic signed [GB+1:0]   sum;
    logic [GB+3:0]          tsh;
    logic [GB-1:0]          tsat;
    logic [S-1:0]           mag;
    logic [S+2*F-1:0]       pfull;
    logic [S+3:0]           psh;
    logic [S+3:0]           limit;
    logic [S+3:0]           psat;

    assign vol_diff = chvol_reg != vol;
    assign res      = res_reg;

    always_comb begin
        trial    = {dr_reg, dq_reg[GB-1]};
        ge       = trial >= {1'b0, divisor};
        r_diff   = ge ? trial - {1'b0, divisor} : trial;
        q_next   = {dq_reg[GB-2:0], ge};
        diff     = $signed({1'b0, tgt_reg}) - $signed({1'b0, cur_reg});
        diff_mag = diff[GB] ? GB'(-diff) : diff[GB-1:0];
        sprod_full = step_reg * $signed({1'b0, ctl.t});
        addend   = ctl.upd_frame ? (GB+2)'(step_reg) : sprod_reg;
        sum      = $signed({2'b00, cur_reg}) + addend;
        tsh      = prod_reg[2*PB-1:4];
        tsat     = (|tsh[GB+3:GB]) ? {GB{1'b1}} : tsh[GB-1:0];
        mag      = sample[S-1] ? S'(-sample) : sample;
        pfull    = {phi_reg, {F{1'b0}}} + (S+2*F)'(plo_reg);
        psh      = pfull[S+2*F-1:IFRAC];
        limit    = neg_reg ? (S+4)'(1) << (S-1) : ((S+4)'(1) << (S-1)) - (S+4)'(1);
        psat     = psh > limit ? limit : psh;
    end

    // settings and gain state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chvol_reg <= PB'(1) << F;
            cur_reg   <= GB'(1) << IFRAC;
            tgt_reg   <= GB'(1) << IFRAC;
            step_reg  <= '0;
        end else begin
            if (ctl.set_vol && sel) begin
                chvol_reg <= vol;
            end
            if (ctl.commit) begin
                tgt_reg <= ctl.muted ? '0 : tsat;
            end
            if (ctl.div_run && ctl.div_last) begin
                step_reg <= dneg_reg ? -$signed({1'b0, q_next}) : $signed({1'b0, q_next});
            end
            if (ctl.upd) begin
                cur_reg <= ctl.snap ? tgt_reg : sum[GB-1:0];
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        prod_reg <= master * chvol_reg;
        if (ctl.div_load) begin
            dneg_reg <= diff[GB];
            dq_reg   <= diff_mag;
            dr_reg   <= '0;
        end else if (ctl.div_run) begin
            dq_reg <= q_next;
            dr_reg <= r_diff[RAMP_BITS-1:0];
        end
        if (ctl.amul) begin
            sprod_reg <= sprod_full[GB+1:0];
        end
        if (ctl.mul1) begin
            plo_reg <= mag * cur_reg[F-1:0];
            phi_reg <= mag * cur_reg[GB-1:F];
            neg_reg <= sample[S-1];
        end
        if (ctl.mul2) begin
            res_reg <= !en ? sample : (neg_reg ? S'(-psat) : psat[S-1:0]);
        end
    end

endmodule

>>> src/multichannel_gain_ramp.sv
// top level of the multichannel gain ramp: command decode, ramp control, output word
// depends on gmr_pkg, gmr_lane and assert_macros.svh
//
// channel  | direction | contents
// s_*      | in        | cmd, target_channel, level, sample_0..sample_n
// m_*      | out       | out_0..out_n, ramp_active (one word per frame)
// cfg_*    | in        | channel_count, ramp_length writes
//
// set commands stay in S_IDLE, commit passes S_COMMIT when commit_ok, advance passes
// S_AMUL and S_UPD if it moves the ramp; a frame passes S_UPD in a ramp, S_MUL1,
// S_MUL2, S_OUT and the output wait; starting a ramp adds the per-lane bit-serial
// step divider; aresetn is synchronous; the result sits in an output register, so a
// stalled m_tready holds only the next frame at its last stage
`include "assert_macros.svh"
module multichannel_gain_ramp #(
    parameter int CHANNELS       = 8,
    parameter int SAMPLE_BITS    = 24,
    parameter int GAIN_FRAC_BITS = 20
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // cmd, target_channel, level, sample_0 .. sample_n
    input  logic [((gmr_pkg::CMD_BITS + $clog2(CHANNELS + 1) + GAIN_FRAC_BITS + 4
                   + CHANNELS * SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // out_0 .. out_n, ramp_active
    output logic [((CHANNELS * SAMPLE_BITS + 1 + 7) / 8) * 8 - 1:0] m_tdata,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [gmr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [gmr_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import gmr_pkg::*;

    localparam int S      = SAMPLE_BITS;
    localparam int PB     = GAIN_FRAC_BITS + 4;
    localparam int GB     = 2 * GAIN_FRAC_BITS;
    localparam int TW     = $clog2(CHANNELS + 1);
    localparam int AW     = $clog2(CHANNELS + 1);
    localparam int DCW    = $clog2(GB);
    localparam int LVL_LO = CMD_BITS + TW;
    localparam int SMP_LO = LVL_LO + PB;
    localparam int OUT_W  = ((CHANNELS * S + 1 + 7) / 8) * 8;

    gmr_state_t state_reg, state_next;

    logic [CCOUNT_BITS-1:0] ccount_reg;
    logic [RAMP_BITS-1:0]   rlen_reg;
    logic [RAMP_BITS-1:0]   rem_reg;
    logic [PB-1:0]          master_reg;
    logic                   muted_reg;
    logic                   pending_reg;
    logic                   changed_reg;
    gmr_cmd_t               cmd_reg;
    logic                   upd_reg;
    logic                   snap_reg;
    logic [RAMP_BITS-1:0]   t_reg;
    logic [DCW-1:0]         dcnt_reg;
    logic [S-1:0]           smp_reg [CHANNELS];
    logic                   m_valid_reg;
    logic [OUT_W-1:0]       m_data_reg;

    logic                   s_fire;
    gmr_cmd_t               cmd_in;
    logic [TW-1:0]          tch_in;
    logic [PB-1:0]          level_in;
    logic [AW-1:0]          active;
    logic                   start_now;
    logic                   upd_now;
    logic                   snap_now;
    logic [RAMP_BITS-1:0]   t_now;
    logic                   commit_ok;
    logic                   out_free;
    logic                   div_last;
    logic                   chan_changed;
    gmr_ctl_t               ctl;
    logic [CHANNELS-1:0]    lane_sel;
    logic [CHANNELS-1:0]    lane_en;
    logic [CHANNELS-1:0]    lane_diff;
    logic [S-1:0]           lane_res [CHANNELS];
    logic [OUT_W-1:0]       out_pack;

    assign s_tready  = state_reg == S_IDLE;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign out_free  = !m_valid_reg || m_tready;
    assign div_last  = dcnt_reg == DCW'(GB - 1);

    // input word decode
    always_comb begin
        cmd_in   = gmr_cmd_t'(s_tdata[CMD_BITS-1:0]);
        tch_in   = s_tdata[CMD_BITS +: TW];
        level_in = s_tdata[LVL_LO +: PB];
        if (32'(ccount_reg) > CHANNELS) begin
            active = AW'(CHANNELS);
        end else begin
            active = AW'(ccount_reg);
        end
        t_now     = (level_in < rem_reg) ? RAMP_BITS'(level_in) : rem_reg;
        commit_ok = (rlen_reg != '0) && changed_reg;
        start_now = 1'b0;
        upd_now   = 1'b0;
        snap_now  = 1'b0;
        case (cmd_in)
            CMD_FRAME: begin
                start_now = (active != '0) && pending_reg;
                upd_now   = (active != '0) && (rem_reg != '0);
                snap_now  = rem_reg == RAMP_BITS'(1);
            end
            CMD_ADVANCE: begin
                start_now = (level_in != '0) && (active != '0) && pending_reg;
                upd_now   = (level_in != '0) && (active != '0) && (t_now != '0);
                snap_now  = t_now == rem_reg;
            end
            default: begin
            end
        endcase
        for (int i = 0; i < CHANNELS; i++) begin
            lane_sel[i] = (tch_in == TW'(CHANNELS)) || (tch_in == TW'(i));
            lane_en[i]  = i < 32'(active);
        end
        chan_changed = |(lane_sel & lane_diff);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    case (cmd_in)
                        CMD_FRAME: begin
                            state_next = start_now ? S_DIV : (upd_now ? S_UPD : S_MUL1);
                        end
                        CMD_ADVANCE: begin
                            state_next = start_now ? S_DIV : (upd_now ? S_AMUL : S_IDLE);
                        end
                        CMD_COMMIT: begin
                            state_next = commit_ok ? S_COMMIT : S_IDLE;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_COMMIT: state_next = S_IDLE;
            S_DIV: begin
                if (div_last) begin
                    if (cmd_reg == CMD_FRAME) begin
                        state_next = upd_reg ? S_UPD : S_MUL1;
                    end else begin
                        state_next = upd_reg ? S_AMUL : S_IDLE;
                    end
                end
            end
            S_AMUL: state_next = S_UPD;
            S_UPD:  state_next = (cmd_reg == CMD_FRAME) ? S_MUL1 : S_IDLE;
            S_MUL1: state_next = S_MUL2;
            S_MUL2: state_next = S_OUT;
            S_OUT:  state_next = out_free ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    // lane controls
    always_comb begin
        ctl           = '0;
        ctl.set_vol   = s_fire && (cmd_in == CMD_SET_CHANNEL);
        ctl.div_load  = s_fire && start_now;
        ctl.div_run   = state_reg == S_DIV;
        ctl.div_last  = div_last;
        ctl.commit    = state_reg == S_COMMIT;
        ctl.muted     = muted_reg;
        ctl.amul      = state_reg == S_AMUL;
        ctl.upd       = state_reg == S_UPD;
        ctl.upd_frame = cmd_reg == CMD_FRAME;
        ctl.snap      = snap_reg;
        ctl.mul1      = state_reg == S_MUL1;
        ctl.mul2      = state_reg == S_MUL2;
        ctl.t         = t_reg;
    end

    // merge of lane results into the output word
    always_comb begin
        out_pack = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            out_pack[i*S +: S] = lane_res[i];
        end
        out_pack[CHANNELS*S] = rem_reg != '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ccount_reg  <= CCOUNT_RESET;
            rlen_reg    <= RAMP_RESET;
            rem_reg     <= '0;
            master_reg  <= PB'(1) << GAIN_FRAC_BITS;
            muted_reg   <= 1'b0;
            pending_reg <= 1'b0;
            changed_reg <= 1'b0;
            dcnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_CHANNEL_COUNT) begin
                    ccount_reg <= cfg_data[CCOUNT_BITS-1:0];
                end else if (cfg_index == REG_RAMP_LENGTH) begin
                    rlen_reg <= cfg_data[RAMP_BITS-1:0];
                end
            end
            if (s_fire) begin
                case (cmd_in)
                    CMD_SET_MASTER: begin
                        if (master_reg != level_in) begin
                            master_reg  <= level_in;
                            changed_reg <= 1'b1;
                        end
                    end
                    CMD_SET_MUTE: begin
                        if (muted_reg != (level_in != '0)) begin
                            muted_reg   <= level_in != '0;
                            changed_reg <= 1'b1;
                        end
                    end
                    CMD_SET_CHANNEL: begin
                        if (chan_changed) begin
                            changed_reg <= 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                if (start_now) begin
                    pending_reg <= 1'b0;
                end
            end
            if (state_reg == S_COMMIT) begin
                rem_reg     <= rlen_reg;
                pending_reg <= 1'b1;
                changed_reg <= 1'b0;
            end
            if (state_reg == S_DIV) begin
                dcnt_reg <= div_last ? '0 : dcnt_reg + DCW'(1);
            end
            if (state_reg == S_UPD) begin
                rem_reg <= (cmd_reg == CMD_FRAME) ? rem_reg - RAMP_BITS'(1) : rem_reg - t_reg;
            end
            if (state_reg == S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // per-word payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_reg  <= cmd_in;
            upd_reg  <= upd_now;
            snap_reg <= snap_now;
            t_reg    <= t_now;
            for (int i = 0; i < CHANNELS; i++) begin
                smp_reg[i] <= s_tdata[SMP_LO + i*S +: S];
            end
        end
        if (state_reg == S_OUT && out_free) begin
            m_data_reg <= out_pack;
        end
    end

    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        gmr_lane #(
            .SAMPLE_BITS    (SAMPLE_BITS),
            .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
        ) u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .sel      (lane_sel[g]),
            .en       (lane_en[g]),
            .vol      (level_in),
            .master   (master_reg),
            .divisor  (rem_reg),
            .sample   (smp_reg[g]),
            .vol_diff (lane_diff[g]),
            .res      (lane_res[g])
        );
    end

    `GMR_ASSERT_NXT(a_ramp_start_divides,
        s_fire && cmd_in == CMD_FRAME && pending_reg && active != '0,
        state_reg == S_DIV, "pending ramp did not start the divider")
    `GMR_ASSERT_NXT(a_remaining_grows_on_commit, state_reg != S_COMMIT,
        rem_reg <= $past(rem_reg), "ramp remaining grew outside a commit")
    `GMR_ASSERT_IMP(a_word_from_out_state, $rose(m_tvalid),
        $past(state_reg == S_OUT), "output word loaded outside the output state")
    `GMR_ASSERT_NXT(a_divider_ends, state_reg == S_DIV && div_last,
        state_reg != S_DIV && dcnt_reg == '0, "divider overran its count")

endmodule
